FILE: rtl/core/bracket_toggle_longest_balanced_assert.svh
// assertion macros for the bracket store block and its checker
// needs clk and arst_n in the scope where a macro is used
`ifndef BRACKET_TOGGLE_LONGEST_BALANCED_ASSERT_SVH
`define BRACKET_TOGGLE_LONGEST_BALANCED_ASSERT_SVH

// clocked check, off while reset is active
`define BTLB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define BTLB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/btlb_pkg.sv
// shared types and constants for the bracket store block
// no dependencies
`default_nettype none

package btlb_pkg;

	localparam int LEN_W  = 11;
	localparam int KIND_W = 2;

	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE = 2'd0,
		KIND_FLIP  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FLIP,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bracket_toggle_longest_balanced.sv
// bracket store with write, flip and longest balanced run query
// depends on btlb_pkg
//
//   channel | direction | handshake            | word
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_data (length_in_use)
//   in      | in        | in_valid/in_stall    | kind, position, bracket_value
//   out     | out       | out_valid/out_stall  | match_length, bad_position
//
// write, bad position and unused kind go from idle straight to done; flip
// writes the read bracket back inverted in a flip state; query scans from
// position to the in-use length (at most MAX_LEN), one store read per cycle
// after reset a clearing pass zeroes all MAX_LEN entries before the first word
// the result register frees the input side while out_stall is high
`default_nettype none

module bracket_toggle_longest_balanced #(
	parameter int MAX_LEN = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [btlb_pkg::LEN_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [btlb_pkg::KIND_W-1:0] kind,
	input  wire logic [btlb_pkg::LEN_W-1:0]  position,
	input  wire logic                        bracket_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [btlb_pkg::LEN_W-1:0]       match_length,
	output logic                             bad_position
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = (LW > btlb_pkg::LEN_W) ? LW : btlb_pkg::LEN_W;

	btlb_pkg::state_t state_q, state_d;

	logic [btlb_pkg::LEN_W-1:0] len_q;

	logic          mem [MAX_LEN];
	logic          rd_q;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wa;
	logic          wd;

	logic [AW-1:0] clr_q, clr_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [CW-1:0] rem_q, rem_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] best_q, best_d;
	logic signed [CW:0] bal_q, bal_d;
	logic          res_bad_q, res_bad_d;

	logic                       out_valid_q;
	logic [btlb_pkg::LEN_W-1:0] match_q;
	logic                       bad_q;
	logic                       out_load;

	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic [CW-1:0] live_w;
	logic [CW-1:0] pos_m1;
	logic          pos_ok;
	logic          out_free;
	logic signed [CW:0] step;
	logic [CW-1:0] cnt_inc;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign match_length = match_q;
	assign bad_position = bad_q;

	assign pos_w    = CW'(position);
	assign len_w    = CW'(len_q);
	assign live_w   = (len_w > CW'(MAX_LEN)) ? CW'(MAX_LEN) : len_w;
	assign pos_m1   = pos_w - CW'(1);
	assign pos_ok   = (pos_w != '0) && (pos_w <= live_w);
	assign out_free = !out_valid_q || !out_stall;
	assign step     = rd_q ? (bal_q + (CW+1)'(1)) : (bal_q - (CW+1)'(1));
	assign cnt_inc  = cnt_q + CW'(1);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		rd_addr   = addr_q;
		we        = 1'b0;
		wa        = addr_q;
		wd        = 1'b0;
		clr_d     = clr_q;
		addr_d    = addr_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		best_d    = best_q;
		bal_d     = bal_q;
		res_bad_d = res_bad_q;
		out_load  = 1'b0;
		case (state_q)
			btlb_pkg::S_CLEAR: begin
				we    = 1'b1;
				wa    = clr_q;
				wd    = 1'b0;
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(MAX_LEN - 1)) begin
					state_d = btlb_pkg::S_IDLE;
				end
			end
			btlb_pkg::S_IDLE: begin
				in_stall = 1'b0;
				rd_addr  = pos_m1[AW-1:0];
				if (in_valid) begin
					addr_d    = pos_m1[AW-1:0];
					rem_d     = live_w - pos_m1;
					cnt_d     = '0;
					best_d    = '0;
					bal_d     = '0;
					res_bad_d = 1'b0;
					state_d   = btlb_pkg::S_DONE;
					case (kind)
						btlb_pkg::KIND_WRITE: begin
							if (pos_ok) begin
								we = 1'b1;
								wa = pos_m1[AW-1:0];
								wd = bracket_value;
							end else begin
								res_bad_d = 1'b1;
							end
						end
						btlb_pkg::KIND_FLIP: begin
							if (pos_ok) begin
								state_d = btlb_pkg::S_FLIP;
							end else begin
								res_bad_d = 1'b1;
							end
						end
						btlb_pkg::KIND_QUERY: begin
							if (pos_ok) begin
								state_d = btlb_pkg::S_SCAN;
							end else begin
								res_bad_d = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			btlb_pkg::S_FLIP: begin
				we      = 1'b1;
				wa      = addr_q;
				wd      = ~rd_q;
				state_d = btlb_pkg::S_DONE;
			end
			btlb_pkg::S_SCAN: begin
				rd_addr = addr_q + AW'(1);
				addr_d  = addr_q + AW'(1);
				bal_d   = step;
				cnt_d   = cnt_inc;
				rem_d   = rem_q - CW'(1);
				if (step == '0) begin
					best_d = cnt_inc;
				end
				// stop when balance drops below start or string ends
				if (step[CW] || rem_q == CW'(1)) begin
					state_d = btlb_pkg::S_DONE;
				end
			end
			btlb_pkg::S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = btlb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = btlb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btlb_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= btlb_pkg::LEN_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_q <= cfg_data;
			end
			clr_q <= clr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q    <= addr_d;
		rem_q     <= rem_d;
		cnt_q     <= cnt_d;
		best_q    <= best_d;
		bal_q     <= bal_d;
		res_bad_q <= res_bad_d;
		if (out_load) begin
			match_q <= best_q[btlb_pkg::LEN_W-1:0];
			bad_q   <= res_bad_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/btlb_check.sv
// port-level checks for the bracket store block, with its bind
// depends on btlb_pkg and bracket_toggle_longest_balanced_assert.svh
`default_nettype none

`include "bracket_toggle_longest_balanced_assert.svh"

module btlb_check (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        cfg_valid,
	input wire logic                        cfg_ready,
	input wire logic [btlb_pkg::LEN_W-1:0]  cfg_data,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic [btlb_pkg::KIND_W-1:0] kind,
	input wire logic [btlb_pkg::LEN_W-1:0]  position,
	input wire logic                        bracket_value,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [btlb_pkg::LEN_W-1:0]  match_length,
	input wire logic                        bad_position
);

	// stalled result word holds
	`BTLB_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(match_length) && $stable(bad_position), "out word changed under stall")

	// one word in flight at a time
	`BTLB_ASSERT(a_one_item, in_valid && !in_stall |=> in_stall, "input taken while busy")

	// bad position never carries a length
	`BTLB_ASSERT(a_bad_zero, out_valid && bad_position |-> match_length == '0, "length on bad position")

	// balanced runs have even length
	`BTLB_ASSERT(a_even_len, out_valid |-> !match_length[0], "odd balanced length")

endmodule

bind bracket_toggle_longest_balanced btlb_check u_btlb_check (.*);

`default_nettype wire
